/* design/pdc_pkg.sv */
`default_nettype none

package pdc_pkg;

   localparam int ADC_BITS_DEFAULT       = 10;
   localparam int GAIN_FRAC_BITS_DEFAULT = 24;

   localparam int LIMIT_W     = 22;
   localparam int SUM_W       = LIMIT_W + 1;
   localparam int DUTY_W      = 16;
   localparam int DUTY_FRAC_W = 15;
   localparam int LED_W       = 5;
   localparam int CSR_INDEX_W = 3;

   localparam int DUTY_MAX = 32767;
   localparam int LED_EDGE = 26214;

   localparam int ZERO_OFFSET_RESET    = 361;
   localparam int P_GAIN_RESET         = 1574122;
   localparam int I_GAIN_RESET         = 2361;
   localparam int D_GAIN_RESET         = 22038;
   localparam int INTEGRAL_LIMIT_RESET = 2664535;
   localparam int TRIP_LOW_RESET       = 260;
   localparam int TRIP_HIGH_RESET      = 450;

   localparam logic [LED_W-1:0] LED_HIGH     = 5'd8;
   localparam logic [LED_W-1:0] LED_POSITIVE = 5'd4;
   localparam logic [LED_W-1:0] LED_NEGATIVE = 5'd2;
   localparam logic [LED_W-1:0] LED_LOW      = 5'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZERO_OFFSET    = 3'd0,
      CSR_P_GAIN         = 3'd1,
      CSR_I_GAIN         = 3'd2,
      CSR_D_GAIN         = 3'd3,
      CSR_INTEGRAL_LIMIT = 3'd4,
      CSR_TRIP_LOW       = 3'd5,
      CSR_TRIP_HIGH      = 3'd6
   } csr_index_type;

   // live: normal update, trip: this item latched the fault, frozen: after the fault
   typedef enum logic [1:0] {
      KIND_LIVE   = 2'd0,
      KIND_TRIP   = 2'd1,
      KIND_FROZEN = 2'd2
   } item_kind_type;

endpackage

`default_nettype wire

/* design/pdc_mac.sv */
`default_nettype none

module pdc_mac #(
   parameter int ADC_BITS       = pdc_pkg::ADC_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 load,
   input  wire logic signed [ADC_BITS:0]             err,
   input  wire logic signed [pdc_pkg::SUM_W-1:0]     error_sum,
   input  wire logic signed [ADC_BITS+1:0]           diff,
   input  wire logic        [GAIN_FRAC_BITS-1:0]     p_gain,
   input  wire logic        [GAIN_FRAC_BITS-1:0]     i_gain,
   input  wire logic        [GAIN_FRAC_BITS-1:0]     d_gain,
   output logic signed      [pdc_pkg::DUTY_W-1:0]    duty,
   output logic             [pdc_pkg::LED_W-1:0]     led
);

   localparam int ErrW   = ADC_BITS + 1;
   localparam int DiffW  = ADC_BITS + 2;
   localparam int SumW   = pdc_pkg::SUM_W;
   localparam int PW     = ErrW + GAIN_FRAC_BITS + 1;
   localparam int IW     = SumW + GAIN_FRAC_BITS + 1;
   localparam int DW     = DiffW + GAIN_FRAC_BITS + 1;
   localparam int AccW   = IW + 2;
   localparam int OutShift = GAIN_FRAC_BITS - pdc_pkg::DUTY_FRAC_W;

   localparam logic signed [AccW-1:0] SatHi = AccW'(pdc_pkg::DUTY_MAX);
   localparam logic signed [AccW-1:0] SatLo = -SatHi;
   localparam logic signed [pdc_pkg::DUTY_W-1:0] LedHi = pdc_pkg::DUTY_W'(pdc_pkg::LED_EDGE);
   localparam logic signed [pdc_pkg::DUTY_W-1:0] LedLo = -LedHi;

   logic signed [PW-1:0]   p_prod_ff, p_prod_in;
   logic signed [IW-1:0]   i_prod_ff, i_prod_in;
   logic signed [DW-1:0]   d_prod_ff, d_prod_in;
   logic signed [AccW-1:0] acc;
   logic signed [AccW-1:0] shifted;

   always_comb begin
      p_prod_in = err * $signed({1'b0, p_gain});
      i_prod_in = error_sum * $signed({1'b0, i_gain});
      d_prod_in = diff * $signed({1'b0, d_gain});
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
      end
   end

   // floor shift to Q1.15 then saturate
   always_comb begin
      acc     = AccW'(p_prod_ff) + AccW'(i_prod_ff) + AccW'(d_prod_ff);
      shifted = acc >>> OutShift;
      if (shifted > SatHi) begin
         duty = SatHi[pdc_pkg::DUTY_W-1:0];
      end else if (shifted < SatLo) begin
         duty = SatLo[pdc_pkg::DUTY_W-1:0];
      end else begin
         duty = shifted[pdc_pkg::DUTY_W-1:0];
      end
   end

   always_comb begin
      if (duty > LedHi) begin
         led = pdc_pkg::LED_HIGH;
      end else if (!duty[pdc_pkg::DUTY_W-1]) begin
         led = pdc_pkg::LED_POSITIVE;
      end else if (duty >= LedLo) begin
         led = pdc_pkg::LED_NEGATIVE;
      end else begin
         led = pdc_pkg::LED_LOW;
      end
   end

endmodule

`default_nettype wire

/* design/pendulum_pid_duty_controller_unit.sv */
// Path of an item: the edge that accepts it updates the state, then the product registers load,
// then sum, shift and saturate go into the result register; a stall can hold any stage.
// Throughput: one item per cycle while rsp_ready holds; stages advance alone, so bubbles collapse.
// Reset: synchronous, active high; configuration registers return to their default values,
// the error sum, previous error, held LED code and fault latch clear.
`default_nettype none

module pendulum_pid_duty_controller_unit #(
   parameter int ADC_BITS       = pdc_pkg::ADC_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEFAULT,
   localparam int CsrW = (GAIN_FRAC_BITS > pdc_pkg::LIMIT_W) ? GAIN_FRAC_BITS
                                                               : pdc_pkg::LIMIT_W
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [ADC_BITS-1:0]                req_adc_sample,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [pdc_pkg::DUTY_W-1:0]       rsp_duty,
   output logic [pdc_pkg::LED_W-1:0]               rsp_led_pattern,
   output logic                                    rsp_tripped,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [pdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CsrW-1:0]                    csr_data
);

   localparam int ErrW  = ADC_BITS + 1;
   localparam int DiffW = ADC_BITS + 2;
   localparam int SumW  = pdc_pkg::SUM_W;
   localparam int RawW  = SumW + 1;

   // configuration registers
   logic [ADC_BITS-1:0]          zero_offset_ff, zero_offset_in;
   logic [GAIN_FRAC_BITS-1:0]    p_gain_ff, p_gain_in;
   logic [GAIN_FRAC_BITS-1:0]    i_gain_ff, i_gain_in;
   logic [GAIN_FRAC_BITS-1:0]    d_gain_ff, d_gain_in;
   logic [pdc_pkg::LIMIT_W-1:0]  integral_limit_ff, integral_limit_in;
   logic [ADC_BITS-1:0]          trip_low_ff, trip_low_in;
   logic [ADC_BITS-1:0]          trip_high_ff, trip_high_in;

   // controller state
   logic signed [SumW-1:0]       error_sum_ff, error_sum_in;
   logic signed [ErrW-1:0]       previous_error_ff, previous_error_in;
   logic                         fault_latched_ff, fault_latched_in;
   logic [pdc_pkg::LED_W-1:0]    held_led_ff, held_led_in;

   // pipeline
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [ErrW-1:0]       s1_err_ff, s1_err_in;
   logic signed [SumW-1:0]       s1_sum_ff, s1_sum_in;
   logic signed [DiffW-1:0]      s1_diff_ff, s1_diff_in;
   pdc_pkg::item_kind_type       s1_kind_ff, s1_kind_in;
   logic                         s2_valid_ff, s2_valid_in;
   pdc_pkg::item_kind_type       s2_kind_ff, s2_kind_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [pdc_pkg::DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic [pdc_pkg::LED_W-1:0]    rsp_led_ff, rsp_led_in;
   logic                         rsp_tripped_ff, rsp_tripped_in;

   logic                         accept;
   logic                         csr_write;
   logic                         s1_en;
   logic                         s2_en;
   logic                         rsp_en;
   logic signed [ErrW-1:0]       err;
   logic signed [DiffW-1:0]      diff;
   logic signed [RawW-1:0]       raw_sum;
   logic signed [RawW-1:0]       lim;
   logic signed [SumW-1:0]       sum_clamped;
   logic                         trip;
   logic signed [pdc_pkg::DUTY_W-1:0] mac_duty;
   logic [pdc_pkg::LED_W-1:0]    mac_led;

   assign rsp_en    = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || rsp_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty        = rsp_duty_ff;
   assign rsp_led_pattern = rsp_led_ff;
   assign rsp_tripped     = rsp_tripped_ff;

   // configuration writes
   always_comb begin
      zero_offset_in    = zero_offset_ff;
      p_gain_in         = p_gain_ff;
      i_gain_in         = i_gain_ff;
      d_gain_in         = d_gain_ff;
      integral_limit_in = integral_limit_ff;
      trip_low_in       = trip_low_ff;
      trip_high_in      = trip_high_ff;
      if (csr_write) begin
         case (csr_index)
            pdc_pkg::CSR_ZERO_OFFSET:    zero_offset_in    = csr_data[ADC_BITS-1:0];
            pdc_pkg::CSR_P_GAIN:         p_gain_in         = csr_data[GAIN_FRAC_BITS-1:0];
            pdc_pkg::CSR_I_GAIN:         i_gain_in         = csr_data[GAIN_FRAC_BITS-1:0];
            pdc_pkg::CSR_D_GAIN:         d_gain_in         = csr_data[GAIN_FRAC_BITS-1:0];
            pdc_pkg::CSR_INTEGRAL_LIMIT: integral_limit_in = csr_data[pdc_pkg::LIMIT_W-1:0];
            pdc_pkg::CSR_TRIP_LOW:       trip_low_in       = csr_data[ADC_BITS-1:0];
            pdc_pkg::CSR_TRIP_HIGH:      trip_high_in      = csr_data[ADC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff    <= ADC_BITS'(pdc_pkg::ZERO_OFFSET_RESET);
         p_gain_ff         <= GAIN_FRAC_BITS'(pdc_pkg::P_GAIN_RESET);
         i_gain_ff         <= GAIN_FRAC_BITS'(pdc_pkg::I_GAIN_RESET);
         d_gain_ff         <= GAIN_FRAC_BITS'(pdc_pkg::D_GAIN_RESET);
         integral_limit_ff <= pdc_pkg::LIMIT_W'(pdc_pkg::INTEGRAL_LIMIT_RESET);
         trip_low_ff       <= ADC_BITS'(pdc_pkg::TRIP_LOW_RESET);
         trip_high_ff      <= ADC_BITS'(pdc_pkg::TRIP_HIGH_RESET);
      end else begin
         zero_offset_ff    <= zero_offset_in;
         p_gain_ff         <= p_gain_in;
         i_gain_ff         <= i_gain_in;
         d_gain_ff         <= d_gain_in;
         integral_limit_ff <= integral_limit_in;
         trip_low_ff       <= trip_low_in;
         trip_high_ff      <= trip_high_in;
      end
   end

   // error, derivative, clamped integral and trip check for the accepted item
   always_comb begin
      err     = $signed({1'b0, zero_offset_ff}) - $signed({1'b0, req_adc_sample});
      diff    = DiffW'(err) - DiffW'(previous_error_ff);
      raw_sum = RawW'(error_sum_ff) + RawW'(err);
      lim     = $signed({2'b00, integral_limit_ff});
      if (raw_sum > lim) begin
         sum_clamped = lim[SumW-1:0];
      end else if (raw_sum < -lim) begin
         sum_clamped = SumW'(-lim);
      end else begin
         sum_clamped = raw_sum[SumW-1:0];
      end
      trip = (req_adc_sample > trip_high_ff) || (req_adc_sample < trip_low_ff);
   end

   always_comb begin
      error_sum_in      = error_sum_ff;
      previous_error_in = previous_error_ff;
      fault_latched_in  = fault_latched_ff;
      if (accept && !fault_latched_ff) begin
         error_sum_in      = sum_clamped;
         previous_error_in = err;
         fault_latched_in  = trip;
      end
   end

   always_comb begin
      s1_valid_in = s1_en ? req_valid : s1_valid_ff;
      s1_err_in   = s1_err_ff;
      s1_sum_in   = s1_sum_ff;
      s1_diff_in  = s1_diff_ff;
      s1_kind_in  = s1_kind_ff;
      if (accept) begin
         s1_err_in  = err;
         s1_sum_in  = sum_clamped;
         s1_diff_in = diff;
         if (fault_latched_ff) begin
            s1_kind_in = pdc_pkg::KIND_FROZEN;
         end else if (trip) begin
            s1_kind_in = pdc_pkg::KIND_TRIP;
         end else begin
            s1_kind_in = pdc_pkg::KIND_LIVE;
         end
      end
   end

   always_comb begin
      s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;
      s2_kind_in  = (s2_en && s1_valid_ff) ? s1_kind_ff : s2_kind_ff;
   end

   pdc_mac #(
      .ADC_BITS       (ADC_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .load      (s2_en && s1_valid_ff),
      .err       (s1_err_ff),
      .error_sum (s1_sum_ff),
      .diff      (s1_diff_ff),
      .p_gain    (p_gain_ff),
      .i_gain    (i_gain_ff),
      .d_gain    (d_gain_ff),
      .duty      (mac_duty),
      .led       (mac_led)
   );

   always_comb begin
      rsp_valid_in   = rsp_en ? s2_valid_ff : rsp_valid_ff;
      rsp_duty_in    = rsp_duty_ff;
      rsp_led_in     = rsp_led_ff;
      rsp_tripped_in = rsp_tripped_ff;
      held_led_in    = held_led_ff;
      if (rsp_en && s2_valid_ff) begin
         case (s2_kind_ff)
            pdc_pkg::KIND_LIVE: begin
               rsp_duty_in    = mac_duty;
               rsp_led_in     = mac_led;
               rsp_tripped_in = 1'b0;
               held_led_in    = mac_led;
            end
            pdc_pkg::KIND_TRIP: begin
               rsp_duty_in    = '0;
               rsp_led_in     = mac_led;
               rsp_tripped_in = 1'b1;
               held_led_in    = mac_led;
            end
            default: begin
               rsp_duty_in    = '0;
               rsp_led_in     = held_led_ff;
               rsp_tripped_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff      <= '0;
         previous_error_ff <= '0;
         fault_latched_ff  <= 1'b0;
         held_led_ff       <= '0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         error_sum_ff      <= error_sum_in;
         previous_error_ff <= previous_error_in;
         fault_latched_ff  <= fault_latched_in;
         held_led_ff       <= held_led_in;
         s1_valid_ff       <= s1_valid_in;
         s2_valid_ff       <= s2_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_err_ff      <= s1_err_in;
      s1_sum_ff      <= s1_sum_in;
      s1_diff_ff     <= s1_diff_in;
      s1_kind_ff     <= s1_kind_in;
      s2_kind_ff     <= s2_kind_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_led_ff     <= rsp_led_in;
      rsp_tripped_ff <= rsp_tripped_in;
   end

   a_fault_holds: assert property (@(posedge clock) disable iff (reset)
      fault_latched_ff |=> fault_latched_ff)
      else $error("fault latch released");

   a_frozen_state: assert property (@(posedge clock) disable iff (reset)
      fault_latched_ff |=> ($stable(error_sum_ff) && $stable(previous_error_ff)))
      else $error("controller state moved after fault");

   a_tripped_duty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tripped_ff) |-> (rsp_duty_ff == '0))
      else $error("nonzero duty on a tripped item");

   a_led_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_led_ff))
      else $error("led pattern not a single zone");

   a_led_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tripped_ff) |->
         (rsp_duty_ff[pdc_pkg::DUTY_W-1] == (rsp_led_ff[1] || rsp_led_ff[0])))
      else $error("led zone disagrees with duty sign");

endmodule

`default_nettype wire

/* sim/pendulum_pid_duty_controller_unit_tb.sv */
`timescale 1ns / 100ps

module pendulum_pid_duty_controller_unit_tb;

   localparam int ADC_W          = pdc_pkg::ADC_BITS_DEFAULT;
   localparam int GAIN_W         = pdc_pkg::GAIN_FRAC_BITS_DEFAULT;
   localparam int CSR_DATA_W     = (GAIN_W > pdc_pkg::LIMIT_W) ? GAIN_W : pdc_pkg::LIMIT_W;
   localparam int DUTY_SHIFT     = GAIN_W - pdc_pkg::DUTY_FRAC_W;
   localparam int ERR_W          = ADC_W + 1;
   localparam int ADC_TOP        = (1 << ADC_W) - 1;
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 200;
   localparam int BURST_PHASE    = 4;
   localparam int PAUSE_PHASE    = 6;
   localparam int BURST_CYCLES   = 120;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum logic [1:0] {ROW_ITEM, ROW_WRITE, ROW_TRIP} row_kind_type;

   typedef struct packed {
      logic signed [pdc_pkg::DUTY_W-1:0] duty;
      logic [pdc_pkg::LED_W-1:0]         led;
      logic                              tripped;
   } duty_result_type;

   typedef struct packed {
      row_kind_type                      kind;
      pdc_pkg::csr_index_type            index;
      logic [CSR_DATA_W-1:0]             value;
      logic                              typed;
      logic signed [pdc_pkg::DUTY_W-1:0] duty;
      logic [pdc_pkg::LED_W-1:0]         led;
      logic                              tripped;
   } script_row_type;

   localparam int OPENING_ROWS = 33;
   localparam script_row_type SCRIPT [0:47] = '{
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET, 24'd361, 1'b1, 16'sd0, pdc_pkg::LED_POSITIVE, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd300,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd420,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd450,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd260,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd361,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_TRIP_LOW,       24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_TRIP_HIGH,      24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_P_GAIN,         24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_I_GAIN,         24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_D_GAIN,         24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET, 24'd512, 1'b1, 16'sd0, pdc_pkg::LED_POSITIVE, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET, 24'd1023, 1'b1, 16'sd0, pdc_pkg::LED_POSITIVE, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_D_GAIN,         24'hFFFFFF, 1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_INTEGRAL_LIMIT, 24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_I_GAIN,         24'hFFFFFF, 1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_INTEGRAL_LIMIT, 24'h3FFFFF, 1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_P_GAIN,         24'hFFFFFF, 1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      // closing part: back to the reset settings, then latch the fault and send frozen items
      '{ROW_WRITE, pdc_pkg::CSR_TRIP_LOW, 24'(pdc_pkg::TRIP_LOW_RESET),
        1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_TRIP_HIGH, 24'(pdc_pkg::TRIP_HIGH_RESET),
        1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_ZERO_OFFSET, 24'(pdc_pkg::ZERO_OFFSET_RESET),
        1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_P_GAIN, 24'(pdc_pkg::P_GAIN_RESET),
        1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_I_GAIN, 24'(pdc_pkg::I_GAIN_RESET),
        1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_D_GAIN, 24'(pdc_pkg::D_GAIN_RESET),
        1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_WRITE, pdc_pkg::CSR_INTEGRAL_LIMIT, 24'(pdc_pkg::INTEGRAL_LIMIT_RESET),
        1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd450,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd260,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd361,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_TRIP,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd0,      1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd1023,   1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd361,    1'b0, 16'sd0, 5'd0, 1'b0},
      '{ROW_ITEM,  pdc_pkg::CSR_ZERO_OFFSET,    24'd700,    1'b0, 16'sd0, 5'd0, 1'b0}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [ADC_W-1:0]                  req_adc_sample = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [pdc_pkg::DUTY_W-1:0] rsp_duty;
   logic [pdc_pkg::LED_W-1:0]         rsp_led_pattern;
   logic                              rsp_tripped;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   pdc_pkg::csr_index_type            csr_index = pdc_pkg::CSR_ZERO_OFFSET;
   logic [CSR_DATA_W-1:0]             csr_data = '0;

   // expectation forced by the directed table, travels alongside the offered item
   logic            row_typed = 1'b0;
   duty_result_type row_want = '0;

   idle_mode_type idle_mode = IDLE_NONE;
   logic          rx_burst = 1'b0;
   int            burst_left = 0;
   logic          burst_done = 1'b0;
   int            quiet_cycles = 0;
   int            failures = 0;

   duty_result_type duty_queue [$];

   // controller copy
   logic [ADC_W-1:0]                 model_zero = ADC_W'(pdc_pkg::ZERO_OFFSET_RESET);
   logic [GAIN_W-1:0]                model_p = GAIN_W'(pdc_pkg::P_GAIN_RESET);
   logic [GAIN_W-1:0]                model_i = GAIN_W'(pdc_pkg::I_GAIN_RESET);
   logic [GAIN_W-1:0]                model_d = GAIN_W'(pdc_pkg::D_GAIN_RESET);
   logic [pdc_pkg::LIMIT_W-1:0]      model_limit =
                                        pdc_pkg::LIMIT_W'(pdc_pkg::INTEGRAL_LIMIT_RESET);
   logic [ADC_W-1:0]                 model_trip_low = ADC_W'(pdc_pkg::TRIP_LOW_RESET);
   logic [ADC_W-1:0]                 model_trip_high = ADC_W'(pdc_pkg::TRIP_HIGH_RESET);
   logic signed [pdc_pkg::SUM_W-1:0] error_total = '0;
   logic signed [ERR_W-1:0]          last_error = '0;
   logic                             fault_seen = 1'b0;
   logic [pdc_pkg::LED_W-1:0]        held_zone = '0;

   pendulum_pid_duty_controller_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_adc_sample  (req_adc_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_duty        (rsp_duty),
      .rsp_led_pattern (rsp_led_pattern),
      .rsp_tripped     (rsp_tripped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   function automatic duty_result_type advance_controller(input logic [ADC_W-1:0] sample);
      int     err;
      int     sum_next;
      int     lim;
      longint acc;
      longint scaled;
      if (fault_seen) return '{16'sd0, held_zone, 1'b1};
      err = int'(model_zero) - int'(sample);
      lim = int'(model_limit);
      sum_next = int'(error_total) + err;
      if (sum_next > lim) sum_next = lim;
      if (sum_next < -lim) sum_next = -lim;
      acc = longint'(err) * longint'(model_p)
          + longint'(sum_next) * longint'(model_i)
          + longint'(err - int'(last_error)) * longint'(model_d);
      error_total = sum_next[pdc_pkg::SUM_W-1:0];
      last_error = err[ERR_W-1:0];
      scaled = acc >>> DUTY_SHIFT;
      if (scaled > pdc_pkg::DUTY_MAX) scaled = pdc_pkg::DUTY_MAX;
      if (scaled < -pdc_pkg::DUTY_MAX) scaled = -pdc_pkg::DUTY_MAX;
      if (scaled > pdc_pkg::LED_EDGE) held_zone = pdc_pkg::LED_HIGH;
      else if (scaled >= 0) held_zone = pdc_pkg::LED_POSITIVE;
      else if (scaled >= -pdc_pkg::LED_EDGE) held_zone = pdc_pkg::LED_NEGATIVE;
      else held_zone = pdc_pkg::LED_LOW;
      if (sample > model_trip_high || sample < model_trip_low) begin
         fault_seen = 1'b1;
         return '{16'sd0, held_zone, 1'b1};
      end
      return '{scaled[pdc_pkg::DUTY_W-1:0], held_zone, 1'b0};
   endfunction

   function automatic void flag_mismatch(input string what);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, what);
   endfunction

   // predict on every accepted item, check every accepted result
   always @(posedge clock) begin
      duty_result_type predicted;
      duty_result_type want;
      if (!reset && req_valid && req_ready) begin
         predicted = advance_controller(req_adc_sample);
         duty_queue.push_back(row_typed ? row_want : predicted);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_queue.size() == 0) begin
            flag_mismatch($sformatf("unexpected result duty %0d led %0d tripped %0d",
                                    rsp_duty, rsp_led_pattern, rsp_tripped));
         end else begin
            want = duty_queue.pop_front();
            if (rsp_duty !== want.duty || rsp_led_pattern !== want.led
                || rsp_tripped !== want.tripped)
               flag_mismatch($sformatf(
                  "duty %0d/%0d led %0d/%0d tripped %0d/%0d (expected/actual)",
                  want.duty, rsp_duty, want.led, rsp_led_pattern,
                  want.tripped, rsp_tripped));
         end
      end
   end

   always @(posedge clock) begin
      if (rx_burst && !burst_done) begin
         burst_done = 1'b1;
         burst_left = BURST_CYCLES;
      end
      if (burst_left > 0) begin
         burst_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 76);
            IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 33);
            default:       rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic sender_holds();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 76;
         IDLE_BOTH:   return $urandom_range(99) < 33;
         default:     return 1'b0;
      endcase
   endfunction

   task automatic send_sample(input logic [ADC_W-1:0] sample, input logic typed,
                              input duty_result_type want);
      csr_valid <= 1'b0;
      while (sender_holds()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= sample;
      row_typed <= typed;
      row_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (duty_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input pdc_pkg::csr_index_type index,
                            input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pdc_pkg::CSR_ZERO_OFFSET:    model_zero = value[ADC_W-1:0];
         pdc_pkg::CSR_P_GAIN:         model_p = value[GAIN_W-1:0];
         pdc_pkg::CSR_I_GAIN:         model_i = value[GAIN_W-1:0];
         pdc_pkg::CSR_D_GAIN:         model_d = value[GAIN_W-1:0];
         pdc_pkg::CSR_INTEGRAL_LIMIT: model_limit = value[pdc_pkg::LIMIT_W-1:0];
         pdc_pkg::CSR_TRIP_LOW:       model_trip_low = value[ADC_W-1:0];
         pdc_pkg::CSR_TRIP_HIGH:      model_trip_high = value[ADC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic walk_script(input int first, input int stop);
      script_row_type row;
      logic [ADC_W-1:0] sample;
      for (int k = first; k < stop; k++) begin
         row = SCRIPT[k];
         case (row.kind)
            ROW_WRITE: write_reg(row.index, row.value);
            ROW_TRIP: begin
               case ($urandom_range(3))
                  0:       sample = model_trip_low - 1'b1;
                  1:       sample = model_trip_high + 1'b1;
                  2:       sample = '0;
                  default: sample = ADC_W'(ADC_TOP);
               endcase
               send_sample(sample, 1'b0, '0);
            end
            default: send_sample(row.value[ADC_W-1:0], row.typed,
                                 '{row.duty, row.led, row.tripped});
         endcase
      end
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_scaled(input int width);
      logic [CSR_DATA_W-1:0] all_ones;
      all_ones = (CSR_DATA_W'(1) << width) - 1'b1;
      case ($urandom_range(7))
         0:       return '0;
         1:       return all_ones;
         default: return CSR_DATA_W'($urandom)
                         & ((CSR_DATA_W'(1) << $urandom_range(width, 1)) - 1'b1);
      endcase
   endfunction

   task automatic shuffle_settings(input logic wide);
      int lo;
      int hi;
      lo = wide ? 0 : $urandom_range(ADC_TOP);
      hi = wide ? ADC_TOP : $urandom_range(ADC_TOP, lo);
      write_reg(pdc_pkg::CSR_TRIP_LOW, CSR_DATA_W'(lo));
      write_reg(pdc_pkg::CSR_TRIP_HIGH, CSR_DATA_W'(hi));
      write_reg(pdc_pkg::CSR_ZERO_OFFSET, CSR_DATA_W'($urandom_range(ADC_TOP)));
      write_reg(pdc_pkg::CSR_P_GAIN, pick_scaled(GAIN_W));
      write_reg(pdc_pkg::CSR_I_GAIN, pick_scaled(GAIN_W));
      write_reg(pdc_pkg::CSR_D_GAIN, pick_scaled(GAIN_W));
      write_reg(pdc_pkg::CSR_INTEGRAL_LIMIT, pick_scaled(pdc_pkg::LIMIT_W));
   endtask

   // mostly small errors around the zero angle, now and then anywhere in the window
   function automatic logic [ADC_W-1:0] pick_sample();
      int lo;
      int hi;
      int s;
      lo = int'(model_trip_low);
      hi = int'(model_trip_high);
      if ($urandom_range(3) == 0) s = int'($urandom_range(hi, lo));
      else s = int'(model_zero) - 20 + int'($urandom_range(40));
      if (s < lo) s = lo;
      if (s > hi) s = hi;
      return s[ADC_W-1:0];
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      walk_script(0, OPENING_ROWS);
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_mode <= idle_mode_type'(phase % 4);
         shuffle_settings(phase == 0 || $urandom_range(1) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == BURST_PHASE && n == 40) rx_burst <= 1'b1;
            if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) wait_idle();
            send_sample(pick_sample(), 1'b0, '0);
         end
      end
      idle_mode <= IDLE_BOTH;
      walk_script(OPENING_ROWS, $size(SCRIPT));
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && duty_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
design/pdc_pkg.sv
design/pdc_mac.sv
design/pendulum_pid_duty_controller_unit.sv
sim/pendulum_pid_duty_controller_unit_tb.sv
